>>> design/lfbi_pkg.sv
// Package for the lidar frame brake indicator.
// Holds frame phase codes, indicator codes, register indexes and shared types.
// No dependencies; compiled first.
package lfbi_pkg;

   localparam int unsigned TRAIL_BYTES = 5;

   localparam logic [7:0] HEADER_BYTE = 8'h59;

   localparam logic [3:0] PHASE_HUNT  = 4'd0;
   localparam logic [3:0] PHASE_HDR2  = 4'd1;
   localparam logic [3:0] PHASE_LOW   = 4'd2;
   localparam logic [3:0] PHASE_HIGH  = 4'd3;
   localparam logic [3:0] PHASE_TRAIL = 4'd4;
   localparam logic [3:0] PHASE_LAST  = 4'(PHASE_TRAIL - 4'd1 + 4'(TRAIL_BYTES));

   localparam logic [15:0] FAR_RESET  = 16'd200;
   localparam logic [15:0] MID_RESET  = 16'd100;
   localparam logic [15:0] NEAR_RESET = 16'd60;

   typedef enum logic [1:0] {
      REG_FAR  = 2'd0,
      REG_MID  = 2'd1,
      REG_NEAR = 2'd2,
      REG_NONE = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      IND_GREEN     = 2'd0,
      IND_YELLOW    = 2'd1,
      IND_RED       = 2'd2,
      IND_FLASH_RED = 2'd3
   } indicator_type;

   typedef struct packed {
      logic        done;
      logic [15:0] distance;
   } frame_type;

endpackage

>>> design/lfbi_if.sv
// Handshake channels of the lidar frame brake indicator: request, response, CSR.
// Each carries valid, ready and its payload. No dependencies.
interface lfbi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfbi_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] distance_cm;
   logic [1:0]  indicator;

   modport source (output valid, output distance_cm, output indicator, input ready);
   modport sink   (input valid, input distance_cm, input indicator, output ready);
endinterface

interface lfbi_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [15:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> design/lfbi_parser.sv
// Frame parser: hunts the two header bytes, assembles the distance, skips trailer.
// Depends on lfbi_pkg.
module lfbi_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_accept,
   input  logic [7:0]         rx_byte,
   output lfbi_pkg::frame_type frame
);
   import lfbi_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic [15:0] held_ff, held_in;
   logic        done;
   logic [15:0] assembled;

   assign assembled = {rx_byte, low_byte_ff};

   always_comb begin
      phase_in    = phase_ff;
      low_byte_in = low_byte_ff;
      held_in     = held_ff;
      done        = 1'b0;
      case (phase_ff)
         PHASE_HUNT: begin
            if (rx_byte == HEADER_BYTE) phase_in = PHASE_HDR2;
         end
         PHASE_HDR2: begin
            phase_in = (rx_byte == HEADER_BYTE) ? PHASE_LOW : PHASE_HUNT;
         end
         PHASE_LOW: begin
            low_byte_in = rx_byte;
            phase_in    = PHASE_HIGH;
         end
         PHASE_HIGH: begin
            held_in = assembled;
            if (TRAIL_BYTES == 0) begin
               done     = 1'b1;
               phase_in = PHASE_HUNT;
            end else begin
               phase_in = PHASE_TRAIL;
            end
         end
         default: begin
            if (phase_ff >= PHASE_LAST) begin
               done     = 1'b1;
               phase_in = PHASE_HUNT;
            end else begin
               phase_in = phase_ff + 4'd1;
            end
         end
      endcase
   end

   assign frame.done     = byte_accept & done;
   assign frame.distance = (phase_ff == PHASE_HIGH) ? assembled : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
      end else if (byte_accept) begin
         phase_ff <= phase_in;
      end
      if (byte_accept) begin
         low_byte_ff <= low_byte_in;
         held_ff     <= held_in;
      end
   end

endmodule

>>> design/lidar_frame_brake_indicator.sv
// Lidar frame brake indicator, top level.
// Output: the response is registered and appears in the cycle after the last byte of a frame is accepted.
// Throughput: one request per cycle while the response register is free or being taken; it frees as it is taken.
// Reset: synchronous; thresholds return to 200/100/60, parser hunts the first header.
// Depends on lfbi_pkg, lfbi_if and lfbi_parser.
module lidar_frame_brake_indicator (
   input  logic clock,
   input  logic reset,
   lfbi_req_if.sink   req_bus,
   lfbi_rsp_if.source rsp_bus,
   lfbi_csr_if.sink   csr_bus
);
   import lfbi_pkg::*;

   logic [15:0]   far_ff, mid_ff, near_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   dist_ff;
   indicator_type ind_ff, ind_in;
   logic          req_accept;
   frame_type     frame;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = ~rsp_valid_ff | rsp_bus.ready;
   assign req_accept    = req_bus.valid & req_bus.ready;

   lfbi_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .rx_byte     (req_bus.rx_byte),
      .frame       (frame)
   );

   always_comb begin
      if (frame.distance > far_ff) begin
         ind_in = IND_GREEN;
      end else if (frame.distance > mid_ff) begin
         ind_in = IND_YELLOW;
      end else if (frame.distance > near_ff) begin
         ind_in = IND_RED;
      end else begin
         ind_in = IND_FLASH_RED;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) rsp_valid_in = 1'b0;
      if (frame.done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         far_ff       <= FAR_RESET;
         mid_ff       <= MID_RESET;
         near_ff      <= NEAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            case (reg_index_type'(csr_bus.reg_index))
               REG_FAR:  far_ff  <= csr_bus.wr_data;
               REG_MID:  mid_ff  <= csr_bus.wr_data;
               REG_NEAR: near_ff <= csr_bus.wr_data;
               default: ;
            endcase
         end
      end
      if (frame.done) begin
         dist_ff <= frame.distance;
         ind_ff  <= ind_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.distance_cm = dist_ff;
   assign rsp_bus.indicator   = ind_ff;

endmodule
